[rtl/vtr_pkg.sv]
// Shared types and constants for the virtual trackball rotation core.
`timescale 1ns / 1ps
`default_nettype none

package vtr_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int REG_W          = 12;
  localparam int AXIS_W         = 27;
  localparam int ANGLE_W        = 14;
  localparam int CFG_IDX_W      = 1;

  localparam logic [REG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] HEIGHT_RST = 12'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

  // operation codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_MOVE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_RSTART,
    S_ROOT,
    S_WAIT
  } state_e;

  // one entry per product of the multiply-accumulate program
  typedef enum logic [3:0] {
    ST_RR,
    ST_DXDX,
    ST_DYDY,
    ST_AX_P,
    ST_AX_N,
    ST_AY_P,
    ST_AY_N,
    ST_AZ_P,
    ST_AZ_N,
    ST_TXTX,
    ST_TYTY,
    ST_TZTZ
  } step_e;

  typedef struct packed {
    logic mul_en;  // register the product
    logic acc_en;  // fold the product into the accumulator
    logic clear;   // start a new sum
    logic sub;     // subtract instead of add
  } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/vtr_isqrt.sv]
// Iterative floor square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module vtr_isqrt #(
  parameter int RW = 30
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RW-1:0]     rad_i,
  output logic                   done_o,
  output logic [RW/2-1:0]        root_o
);

  localparam int HW  = RW / 2;
  localparam int CW  = $clog2(HW);

  logic [RW-1:0]   rad_q, rad_d;
  logic [HW:0]     rem_q, rem_d;
  logic [HW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [HW+2:0]   rem_sh;
  logic [HW+2:0]   trial;
  logic [HW+2:0]   diff;
  logic            ge;

  assign rem_sh = {rem_q, rad_q[RW-1:RW-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[RW-3:0], 2'b00};
      rem_d  = ge ? diff[HW:0] : rem_sh[HW:0];
      root_d = {root_q[HW-2:0], ge};
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(HW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/vtr_mac.sv]
// Shared multiplier with registered product and accumulator.
`timescale 1ns / 1ps
`default_nettype none

module vtr_mac #(
  parameter int MW = 15,
  parameter int AW = 32
) (
  input  wire logic                clk_i,
  input  wire vtr_pkg::mac_ctrl_t  ctrl_i,
  input  wire logic signed [MW-1:0] a_i,
  input  wire logic signed [MW-1:0] b_i,
  output logic signed [AW-1:0]     acc_o
);

  localparam int PW = 2 * MW;

  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] prod_x;

  assign base   = ctrl_i.clear ? '0 : acc_q;
  assign prod_x = AW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_en) begin
      acc_d = ctrl_i.sub ? (base - prod_x) : (base + prod_x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[rtl/virtual_trackball_rotation_core.sv]
// Top level of the virtual trackball rotation core: sequencer and datapath registers.
//
// Usage:
//   Configuration: cfg_we_i writes cfg_data_i into window_width (index 0) or
//   window_height (index 1); write only while the core is idle.
//   Input channel (in_valid_i / in_stall_o): one transfer carries an operation
//   and a pointer position. Begin drag stores the mapped sphere vector as the
//   start vector and yields no result; move yields one result transfer.
//   Output channel (out_valid_o / out_stall_i): axis = start x end, angle_x2 =
//   floor length of (end - start).
//   Sequence: the core takes one transfer at a time. A begin drag runs three
//   products and one square root; a move runs all twelve products and two
//   square roots, then loads its result. The time is set by the one shared
//   multiplier (a multiply state and an accumulate state per product) and
//   the bit-serial square root used twice, with MW = max(COORD_BITS, 12) + 2
//   root bits per use. in_stall_o is high for the whole computation.
//   A finished result sits in the output register; the core takes the next
//   item meanwhile, and only holds in its final state if a second result is
//   ready while the first is still stalled.
//   Reset: registers return to 640 x 480, the start vector to zero, no
//   result pending.
`timescale 1ns / 1ps
`default_nettype none

module virtual_trackball_rotation_core #(
  parameter int COORD_BITS = vtr_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [vtr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [vtr_pkg::REG_W-1:0]        cfg_data_i,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             operation_i,
  input  wire logic signed [COORD_BITS-1:0]     pointer_x_i,
  input  wire logic signed [COORD_BITS-1:0]     pointer_y_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [vtr_pkg::AXIS_W-1:0]     axis_x_o,
  output logic signed [vtr_pkg::AXIS_W-1:0]     axis_y_o,
  output logic signed [vtr_pkg::AXIS_W-1:0]     axis_z_o,
  output logic [vtr_pkg::ANGLE_W-1:0]           angle_x2_o
);

  localparam int REG_W   = vtr_pkg::REG_W;
  localparam int AXIS_W  = vtr_pkg::AXIS_W;
  localparam int ANGLE_W = vtr_pkg::ANGLE_W;
  // offset from center: pointer minus up to 2047
  localparam int DX_W = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;
  // multiplier operand, wide enough for end - start
  localparam int MW   = DX_W + 1;
  localparam int PW   = 2 * MW;
  localparam int AW   = PW + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= vtr_pkg::WIDTH_RST;
      height_q <= vtr_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vtr_pkg::REG_WINDOW_WIDTH:  width_q  <= cfg_data_i;
        vtr_pkg::REG_WINDOW_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  vtr_pkg::state_e state_q, state_d;
  vtr_pkg::step_e  step_q, step_d;

  logic in_xfer, out_xfer;
  logic root_done;
  logic [MW-1:0] root;
  logic signed [AW-1:0] acc;
  vtr_pkg::mac_ctrl_t mac_ctrl;
  logic root_start;
  logic group_end;

  assign in_stall_o = (state_q != vtr_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;

  // last product of each sum
  always_comb begin
    group_end = 1'b0;
    unique case (step_q) inside
      vtr_pkg::ST_DYDY, vtr_pkg::ST_AX_N, vtr_pkg::ST_AY_N,
      vtr_pkg::ST_AZ_N, vtr_pkg::ST_TZTZ: group_end = 1'b1;
      default:                            group_end = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic                    op_q;
  logic signed [DX_W-1:0]  dx_q, dy_q;    // end vector offsets
  logic [REG_W-1:0]        r_q;           // sphere radius
  logic [REG_W-1:0]        ez_q;
  logic signed [DX_W-1:0]  sdx_q, sdy_q;  // start vector
  logic [REG_W-1:0]        sdz_q;
  logic signed [AXIS_W-1:0] ax_q, ay_q, az_q;
  logic [ANGLE_W-1:0]      angle_q;
  logic                    out_valid_q;
  logic signed [AXIS_W-1:0] out_ax_q, out_ay_q, out_az_q;
  logic [ANGLE_W-1:0]      out_angle_q;

  logic signed [DX_W-1:0] half_w, half_h;
  logic                   load_out;

  assign half_w   = DX_W'($signed({1'b0, width_q[REG_W-1:1]}));
  assign half_h   = DX_W'($signed({1'b0, height_q[REG_W-1:1]}));
  assign load_out = (state_q == vtr_pkg::S_WAIT) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      vtr_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = vtr_pkg::S_MUL;
          step_d  = vtr_pkg::ST_RR;
        end
      end
      vtr_pkg::S_MUL: state_d = vtr_pkg::S_ACC;
      vtr_pkg::S_ACC: begin
        if (step_q == vtr_pkg::ST_DYDY || step_q == vtr_pkg::ST_TZTZ) begin
          state_d = vtr_pkg::S_RSTART;
        end else begin
          state_d = vtr_pkg::S_MUL;
          step_d  = vtr_pkg::step_e'(step_q + 4'd1);
        end
      end
      vtr_pkg::S_RSTART: state_d = vtr_pkg::S_ROOT;
      vtr_pkg::S_ROOT: begin
        if (root_done) begin
          if (step_q == vtr_pkg::ST_TZTZ) begin
            state_d = vtr_pkg::S_WAIT;
          end else if (op_q == vtr_pkg::OP_BEGIN) begin
            state_d = vtr_pkg::S_IDLE;
          end else begin
            state_d = vtr_pkg::S_MUL;
            step_d  = vtr_pkg::ST_AX_P;
          end
        end
      end
      vtr_pkg::S_WAIT: begin
        if (load_out) begin
          state_d = vtr_pkg::S_IDLE;
        end
      end
      default: state_d = vtr_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output decode: MAC control, operand selection, root start
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] r_s, dx_s, dy_s, ez_s, sdx_s, sdy_s, sdz_s;
  logic signed [MW-1:0] tx_s, ty_s, tz_s;
  logic signed [MW-1:0] opa, opb;
  logic [PW-1:0]        rad;

  assign r_s   = MW'($signed({1'b0, r_q}));
  assign ez_s  = MW'($signed({1'b0, ez_q}));
  assign sdz_s = MW'($signed({1'b0, sdz_q}));
  assign dx_s  = MW'(dx_q);
  assign dy_s  = MW'(dy_q);
  assign sdx_s = MW'(sdx_q);
  assign sdy_s = MW'(sdy_q);
  assign tx_s  = dx_s - sdx_s;
  assign ty_s  = dy_s - sdy_s;
  assign tz_s  = ez_s - sdz_s;

  // a negative r^2 - d^2 means off the sphere: root of zero
  assign rad = acc[AW-1] ? '0 : acc[PW-1:0];

  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.mul_en = (state_q == vtr_pkg::S_MUL);
    mac_ctrl.acc_en = (state_q == vtr_pkg::S_ACC);
    root_start      = (state_q == vtr_pkg::S_RSTART);
    opa = r_s;
    opb = r_s;
    unique case (step_q)
      vtr_pkg::ST_RR:   begin opa = r_s;   opb = r_s;  mac_ctrl.clear = 1'b1; end
      vtr_pkg::ST_DXDX: begin opa = dx_s;  opb = dx_s; mac_ctrl.sub   = 1'b1; end
      vtr_pkg::ST_DYDY: begin opa = dy_s;  opb = dy_s; mac_ctrl.sub   = 1'b1; end
      vtr_pkg::ST_AX_P: begin opa = sdy_s; opb = ez_s; mac_ctrl.clear = 1'b1; end
      vtr_pkg::ST_AX_N: begin opa = sdz_s; opb = dy_s; mac_ctrl.sub   = 1'b1; end
      vtr_pkg::ST_AY_P: begin opa = sdz_s; opb = dx_s; mac_ctrl.clear = 1'b1; end
      vtr_pkg::ST_AY_N: begin opa = sdx_s; opb = ez_s; mac_ctrl.sub   = 1'b1; end
      vtr_pkg::ST_AZ_P: begin opa = sdx_s; opb = dy_s; mac_ctrl.clear = 1'b1; end
      vtr_pkg::ST_AZ_N: begin opa = sdy_s; opb = dx_s; mac_ctrl.sub   = 1'b1; end
      vtr_pkg::ST_TXTX: begin opa = tx_s;  opb = tx_s; mac_ctrl.clear = 1'b1; end
      vtr_pkg::ST_TYTY: begin opa = ty_s;  opb = ty_s; end
      vtr_pkg::ST_TZTZ: begin opa = tz_s;  opb = tz_s; end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  vtr_mac #(
    .MW (MW),
    .AW (AW)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (opa),
    .b_i    (opb),
    .acc_o  (acc)
  );

  vtr_isqrt #(
    .RW (PW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (rad),
    .done_o  (root_done),
    .root_o  (root)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vtr_pkg::S_IDLE;
      step_q      <= vtr_pkg::ST_RR;
      out_valid_q <= 1'b0;
      sdx_q       <= '0;
      sdy_q       <= '0;
      sdz_q       <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      // begin drag: latch the mapped vector as the new start
      if (state_q == vtr_pkg::S_ROOT && root_done && step_q == vtr_pkg::ST_DYDY &&
          op_q == vtr_pkg::OP_BEGIN) begin
        sdx_q <= dx_q;
        sdy_q <= dy_q;
        sdz_q <= root[REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= operation_i;
      dx_q <= DX_W'(pointer_x_i) - half_w;
      dy_q <= DX_W'(pointer_y_i) - half_h;
      r_q  <= (width_q > height_q) ? height_q : width_q;
    end
    if (state_q == vtr_pkg::S_ROOT && root_done) begin
      if (step_q == vtr_pkg::ST_DYDY) begin
        ez_q <= root[REG_W-1:0];
      end else begin
        angle_q <= root[ANGLE_W-1:0];
      end
    end
    // a finished sum sits in the accumulator until the next group clears it
    if (state_q == vtr_pkg::S_MUL) begin
      case (step_q)
        vtr_pkg::ST_AY_P: ax_q <= acc[AXIS_W-1:0];
        vtr_pkg::ST_AZ_P: ay_q <= acc[AXIS_W-1:0];
        vtr_pkg::ST_TXTX: az_q <= acc[AXIS_W-1:0];
        default: ;
      endcase
    end
    if (load_out) begin
      out_ax_q    <= ax_q;
      out_ay_q    <= ay_q;
      out_az_q    <= az_q;
      out_angle_q <= angle_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis_x_o    = out_ax_q;
  assign axis_y_o    = out_ay_q;
  assign axis_z_o    = out_az_q;
  assign angle_x2_o  = out_angle_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == vtr_pkg::S_WAIT))
    else $error("result raised outside the final state");

  a_root_in_root_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == vtr_pkg::S_ROOT))
    else $error("square root finished while not awaited");

  a_accept_starts_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == vtr_pkg::S_MUL && step_q == vtr_pkg::ST_RR))
    else $error("accepted transfer did not start the product program");

  a_angle_sum_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vtr_pkg::S_RSTART && step_q == vtr_pkg::ST_TZTZ) |-> !acc[AW-1])
    else $error("squared distance negative");

  a_group_end_before_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vtr_pkg::S_RSTART) |-> group_end)
    else $error("square root started mid-sum");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the virtual trackball rotation core.
`timescale 1ns / 1ps

module testbench;

  localparam int CB            = vtr_pkg::COORD_BITS_DEF;
  localparam int AXW           = vtr_pkg::AXIS_W;
  localparam int ANW           = vtr_pkg::ANGLE_W;
  localparam int RGW           = vtr_pkg::REG_W;
  localparam int IXW           = vtr_pkg::CFG_IDX_W;
  localparam int SETTLE_CYCLES = 80;    // settle time, longer than a move takes
  localparam int HOLD_CYCLES   = 400;   // long output hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer before giving up

  // one pointer event on the input channel
  typedef struct {
    logic                 op;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    bit                   wait_drain;  // hold back until every result is in
  } pointer_event_t;

  // one rotation on the output channel
  typedef struct {
    logic signed [AXW-1:0] axis_x;
    logic signed [AXW-1:0] axis_y;
    logic signed [AXW-1:0] axis_z;
    logic [ANW-1:0]        angle;
  } rotation_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [IXW-1:0]              cfg_index_i = vtr_pkg::REG_WINDOW_WIDTH;
  logic [RGW-1:0]              cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic                        operation_i = vtr_pkg::OP_BEGIN;
  logic signed [CB-1:0]        pointer_x_i = '0;
  logic signed [CB-1:0]        pointer_y_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [AXW-1:0]       axis_x_o;
  logic signed [AXW-1:0]       axis_y_o;
  logic signed [AXW-1:0]       axis_z_o;
  logic [ANW-1:0]              angle_x2_o;

  virtual_trackball_rotation_core #(
    .COORD_BITS(CB)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .pointer_x_i (pointer_x_i),
    .pointer_y_i (pointer_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .axis_x_o    (axis_x_o),
    .axis_y_o    (axis_y_o),
    .axis_z_o    (axis_z_o),
    .angle_x2_o  (angle_x2_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // stimulus and scoreboard storage
  pointer_event_t event_q[$];
  rotation_t      rotation_q[$];
  int             errors = 0;

  // idling knobs, written by the sequencer with nonblocking assignments
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_req        = 0;  // bumped to ask for one long output hold-off

  // predictor copy of the registers and the drag start vector
  logic [RGW-1:0]     window_w = vtr_pkg::WIDTH_RST;
  logic [RGW-1:0]     window_h = vtr_pkg::HEIGHT_RST;
  logic signed [13:0] drag_x  = '0;
  logic signed [13:0] drag_y  = '0;
  logic [11:0]        drag_z  = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // pointer position -> vector on the sphere, using the current window size
  function automatic void sphere_point(input logic signed [CB-1:0] px, py,
                                       output longint vx, vy, vz);
    longint w, h, r, d2, r2;
    w  = longint'(window_w);
    h  = longint'(window_h);
    r  = (w > h) ? h : w;
    vx = longint'(px) - w / 2;
    vy = longint'(py) - h / 2;
    d2 = vx * vx + vy * vy;
    r2 = r * r;
    // outside the sphere (and exactly on it) the z component is zero
    vz = (d2 > r2) ? 0 : longint'(floor_root(r2 - d2));
  endfunction

  // apply one accepted transfer: begin drag stores, move predicts a rotation
  function automatic void track_pointer(input logic op, input logic signed [CB-1:0] px, py);
    longint    ex, ey, ez, sx, sy, sz, tx, ty, tz;
    rotation_t rot;
    sphere_point(px, py, ex, ey, ez);
    if (op == vtr_pkg::OP_BEGIN) begin
      drag_x = 14'(ex);
      drag_y = 14'(ey);
      drag_z = 12'(ez);
    end else begin
      sx = longint'(drag_x);
      sy = longint'(drag_y);
      sz = longint'(drag_z);
      // products are taken at full width, then cut to the field widths
      rot.axis_x = AXW'(sy * ez - sz * ey);
      rot.axis_y = AXW'(sz * ex - sx * ez);
      rot.axis_z = AXW'(sx * ey - sy * ex);
      tx = ex - sx;
      ty = ey - sy;
      tz = ez - sz;
      rot.angle = ANW'(floor_root(tx * tx + ty * ty + tz * tz));
      rotation_q.push_back(rot);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds the input channel from event_q and predicts on each transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    pointer_event_t ev;
    logic           next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        track_pointer(operation_i, pointer_x_i, pointer_y_i);
        next_valid = 1'b0;
      end
      // offer the next event unless idling; a stalled payload stays put
      if (!next_valid && event_q.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct &&
          !(event_q[0].wait_drain && rotation_q.size() != 0)) begin
        ev = event_q.pop_front();
        operation_i <= ev.op;
        pointer_x_i <= ev.x;
        pointer_y_i <= ev.y;
        next_valid  = 1'b1;
      end
      in_valid_i <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output transfer against the oldest predicted rotation
  // ---------------------------------------------------------------------------

  int hold_seen = 0;
  int hold_left = 0;

  task automatic compare_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    rotation_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rotation_q.size() == 0) begin
          $display("%0t: unexpected rotation, expected none, got %0d %0d %0d angle %0d",
                   $time, axis_x_o, axis_y_o, axis_z_o, angle_x2_o);
          errors++;
        end else begin
          want = rotation_q.pop_front();
          compare_field("axis_x", 32'(want.axis_x), 32'(axis_x_o));
          compare_field("axis_y", 32'(want.axis_y), 32'(axis_y_o));
          compare_field("axis_z", 32'(want.axis_z), 32'(axis_z_o));
          compare_field("angle_x2", 32'(want.angle), 32'(angle_x2_o));
        end
      end
      // a long hold-off lets the core fill up and stall its input
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  task automatic queue_event(input logic op, input int x, y, input bit drain = 1'b0);
    pointer_event_t ev;
    ev.op         = op;
    ev.x          = CB'(x);
    ev.y          = CB'(y);
    ev.wait_drain = drain;
    event_q.push_back(ev);
  endtask

  // mostly inside the window, some anywhere, some right on the sphere edge
  task automatic pick_position(output int x, y);
    int w, h, r, pick;
    w    = int'(window_w);
    h    = int'(window_h);
    r    = (w > h) ? h : w;
    pick = $urandom_range(99);
    if (pick < 65) begin
      x = $urandom_range(w, 0);
      y = $urandom_range(h, 0);
    end else if (pick < 85) begin
      x = $signed(CB'($urandom));
      y = $signed(CB'($urandom));
    end else begin
      x = w / 2;
      y = h / 2;
      case ($urandom_range(3))
        0: x = x + r;
        1: x = x - r;
        2: y = y + r;
        default: y = y - r;
      endcase
      if (x > 4095 || y > 4095) begin
        x = w / 2;
        y = h / 2;
      end
    end
  endtask

  // drags (a begin then a few moves) with some stray events mixed in
  task automatic queue_drags(input int count, input bit pause_mid);
    int n, moves, x, y;
    bit drain;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 15) begin
        pick_position(x, y);
        queue_event($urandom_range(1) ? vtr_pkg::OP_MOVE : vtr_pkg::OP_BEGIN, x, y);
        n++;
      end else begin
        pick_position(x, y);
        drain = pause_mid && (n >= count / 2) && (n < count / 2 + 1);
        queue_event(vtr_pkg::OP_BEGIN, x, y, drain);
        n++;
        moves = $urandom_range(6, 1);
        for (int m = 0; m < moves; m++) begin
          pick_position(x, y);
          queue_event(vtr_pkg::OP_MOVE, x, y);
          n++;
        end
      end
    end
  endtask

  // core quiet: nothing queued or offered, every rotation seen, then settle
  task automatic wait_quiet();
    while (event_q.size() != 0 || in_valid_i || rotation_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [RGW-1:0] w, h);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= vtr_pkg::REG_WINDOW_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= vtr_pkg::REG_WINDOW_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_w = w;
    window_h = h;
  endtask

  task automatic run_phase(input logic [RGW-1:0] w, h, input int idle, stall, count,
                           input bit squeeze);
    wait_quiet();
    set_window(w, h);
    sender_idle_pct <= idle;
    stall_pct       <= stall;
    if (squeeze) hold_req <= hold_req + 1;
    queue_drags(count, squeeze);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed events at the reset window 640 x 480: center (320, 240), radius 480
    queue_event(vtr_pkg::OP_MOVE, 320, 240);     // move with no drag yet: zero start vector
    queue_event(vtr_pkg::OP_BEGIN, 320, 240);    // start at the sphere pole
    queue_event(vtr_pkg::OP_MOVE, 800, 240);     // on the edge along x
    queue_event(vtr_pkg::OP_MOVE, 608, 624);     // on the edge, 288-384-480 triangle
    queue_event(vtr_pkg::OP_MOVE, 4095, 4095);   // far outside, top corner of the range
    queue_event(vtr_pkg::OP_MOVE, -4096, -4096); // far outside, bottom corner
    queue_event(vtr_pkg::OP_BEGIN, -4096, 4095, 1'b1);
    queue_event(vtr_pkg::OP_MOVE, 4095, -4096);  // largest products, wrap into the fields
    queue_event(vtr_pkg::OP_MOVE, -4096, 4095);  // same point as start: zero rotation
    queue_event(vtr_pkg::OP_BEGIN, 4095, -4096);
    queue_event(vtr_pkg::OP_MOVE, -4096, 4095);
    queue_event(vtr_pkg::OP_BEGIN, 320, -240);   // start on the edge along -y
    queue_event(vtr_pkg::OP_MOVE, -160, 240);    // end on the edge along -x
    queue_event(vtr_pkg::OP_BEGIN, 0, 0);
    queue_event(vtr_pkg::OP_MOVE, 640, 480);
    queue_event(vtr_pkg::OP_BEGIN, -1, -1);
    queue_event(vtr_pkg::OP_MOVE, 0, 0);
    queue_event(vtr_pkg::OP_MOVE, 1, 1);

    // random drags; the drag start carries over each window change
    run_phase(12'd4095, 12'd4095, 0, 0, 150, 1'b0);
    run_phase(12'd1, 12'd4095, 63, 0, 150, 1'b0);
    run_phase(12'd0, 12'd0, 0, 63, 150, 1'b0);          // zero-sized window
    run_phase(RGW'($urandom_range(4095, 1)), RGW'($urandom_range(4095, 1)),
              25, 25, 150, 1'b0);
    run_phase(vtr_pkg::WIDTH_RST, vtr_pkg::HEIGHT_RST, 0, 0, 150,
              1'b1);                                    // long hold-off and a drain pause
    run_phase(12'd4095, 12'd1, 0, 0, 150, 1'b0);
    run_phase(RGW'($urandom_range(4095, 1)), RGW'($urandom_range(4095, 1)),
              63, 0, 150, 1'b0);
    run_phase(RGW'($urandom_range(4095, 1)), RGW'($urandom_range(4095, 1)),
              25, 25, 150, 1'b0);

    wait_quiet();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
